/* hdl/tla_pkg.sv */
package tla_pkg;

	// line store geometry
	localparam int LINE_DEPTH = 64;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);

	// configuration register
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

	// character codes
	localparam logic [7:0] NL_CHAR  = 8'h0A;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	// command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_ACCEPT   = 3'd0,
		KIND_CHAR     = 3'd1,
		KIND_EMPTY    = 3'd2,
		KIND_OVERFLOW = 3'd3,
		KIND_DISCARD  = 3'd4
	} kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_CAP
	} bk_state_t;

	// drain=1: send out count stored characters; else one result of kind
	typedef struct packed {
		logic          drain;
		kind_t         kind;
		logic [CW-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic          busy;
		logic [CW-1:0] fill;
	} front_stat_t;

	typedef struct packed {
		logic draining;
		logic drain_done;
	} back_stat_t;

endpackage

/* hdl/text_line_assembler_core.sv */
// A single result goes through the command queue and the output register to the result ports;
// a drained line's characters go through the queue, the store read and the output register.
// Throughput: one word per cycle while full is low; full rises while the command queue is full
// and while a newline that drains stored characters holds the store for its read-out.
// Reset: arst_n clears fill count, discard flag, queues and sets the limit to 64;
// line store contents are not cleared.
module text_line_assembler_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	input  logic       chunk_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] result_kind,
	output logic [7:0] line_char,
	output logic       run_last
);

	tla_pkg::cmd_t          cmd_in, cmd_out;
	logic                   cmd_push, cmd_pop, cmd_full, cmd_empty;
	logic                   ram_we, ram_re;
	logic [tla_pkg::AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]             ram_wdata, ram_rdata;
	tla_pkg::front_stat_t   fstat;
	tla_pkg::back_stat_t    bstat;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	tla_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_char   (in_char),
		.chunk_end (chunk_end),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.bstat     (bstat),
		.fstat     (fstat)
	);

	tla_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	tla_ram #(
		.WIDTH (8),
		.DEPTH (tla_pkg::LINE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tla_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_out),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.pop         (pop),
		.empty       (empty),
		.result_kind (result_kind),
		.line_char   (line_char),
		.run_last    (run_last),
		.bstat       (bstat)
	);

`ifndef SYNTHESIS
	// store must not be written while a line is being read out
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && bstat.draining))
		else $error("line store written during drain");

	// drain completion only while the front is held off
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.drain_done |-> fstat.busy)
		else $error("drain done without busy");

	// fill count never passes the store depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.fill <= tla_pkg::CW'(tla_pkg::LINE_DEPTH))
		else $error("fill count out of range");

	// a pending result is not dropped before it is popped
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result lost before pop");
`endif

endmodule

/* hdl/tla_ram.sv */
module tla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// one write port, one registered read port; read data holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

/* hdl/tla_front.sv */
module tla_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [7:0]                   in_char,
	input  logic                         chunk_end,
	input  logic                         cfg_valid,
	input  logic [tla_pkg::LIMIT_W-1:0]  cfg_data,
	input  logic                         cmd_full,
	output logic                         cmd_push,
	output tla_pkg::cmd_t                cmd,
	output logic                         ram_we,
	output logic [tla_pkg::AW-1:0]       ram_waddr,
	output logic [7:0]                   ram_wdata,
	input  tla_pkg::back_stat_t          bstat,
	output tla_pkg::front_stat_t         fstat
);

	logic [tla_pkg::LIMIT_W-1:0] limit_q;
	logic [tla_pkg::CW-1:0]      fill_q, fill_d;
	logic                        skip_q, skip_d;
	logic                        busy_q, busy_d;
	logic [tla_pkg::CW-1:0]      limit_eff;
	logic                        below;
	logic                        printable;
	logic                        accept;

	// stall while the queue is full or a line drain owns the store
	assign full   = cmd_full || busy_q;
	assign accept = push && !full;

	// effective limit is min(line_limit, depth)
	always_comb begin
		if (limit_q > tla_pkg::LIMIT_W'(tla_pkg::LINE_DEPTH)) begin
			limit_eff = tla_pkg::CW'(tla_pkg::LINE_DEPTH);
		end else begin
			limit_eff = tla_pkg::CW'(limit_q);
		end
	end

	assign below     = fill_q < limit_eff;
	assign printable = (in_char >= tla_pkg::PRINT_LO) && (in_char <= tla_pkg::PRINT_HI);

	// classify the word and update the line state
	always_comb begin
		fill_d    = fill_q;
		skip_d    = skip_q;
		busy_d    = busy_q;
		cmd_push  = 1'b0;
		cmd.drain = 1'b0;
		cmd.kind  = tla_pkg::KIND_ACCEPT;
		cmd.count = fill_q;
		ram_we    = 1'b0;
		ram_waddr = fill_q[tla_pkg::AW-1:0];
		ram_wdata = in_char;
		if (bstat.drain_done) begin
			busy_d = 1'b0;
		end
		if (accept) begin
			cmd_push = 1'b1;
			if (skip_q) begin
				cmd.kind = tla_pkg::KIND_DISCARD;
				if (chunk_end) begin
					skip_d = 1'b0;
				end
			end else if (in_char == tla_pkg::NL_CHAR) begin
				fill_d = '0;
				if (below) begin
					if (fill_q == '0) begin
						cmd.kind = tla_pkg::KIND_EMPTY;
					end else begin
						cmd.drain = 1'b1;
						cmd.kind  = tla_pkg::KIND_CHAR;
						busy_d    = 1'b1;
					end
				end else begin
					cmd.kind = tla_pkg::KIND_OVERFLOW;
					skip_d   = !chunk_end;
				end
			end else if (below) begin
				// below the limit implies the store has room
				if (printable) begin
					ram_we = 1'b1;
					fill_d = fill_q + tla_pkg::CW'(1);
				end
			end else begin
				cmd.kind = tla_pkg::KIND_OVERFLOW;
				skip_d   = !chunk_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tla_pkg::LIMIT_RESET;
			fill_q  <= '0;
			skip_q  <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			fill_q <= fill_d;
			skip_q <= skip_d;
			busy_q <= busy_d;
		end
	end

	assign fstat.busy = busy_q;
	assign fstat.fill = fill_q;

endmodule

/* hdl/tla_cmd_fifo.sv */
module tla_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tla_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output tla_pkg::cmd_t rdata,
	output logic          empty
);

	tla_pkg::cmd_t               mem_q [tla_pkg::FIFO_DEPTH];
	logic [tla_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
	logic [tla_pkg::FIFO_CW-1:0] cnt_q;
	logic                        do_wr, do_rd;

	assign full  = cnt_q == tla_pkg::FIFO_CW'(tla_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == tla_pkg::FIFO_AW'(tla_pkg::FIFO_DEPTH - 1)) ?
					'0 : wptr_q + tla_pkg::FIFO_AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == tla_pkg::FIFO_AW'(tla_pkg::FIFO_DEPTH - 1)) ?
					'0 : rptr_q + tla_pkg::FIFO_AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + tla_pkg::FIFO_CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - tla_pkg::FIFO_CW'(1);
			end
		end
	end

endmodule

/* hdl/tla_back.sv */
module tla_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tla_pkg::cmd_t          cmd,
	input  logic                   cmd_empty,
	output logic                   cmd_pop,
	output logic                   ram_re,
	output logic [tla_pkg::AW-1:0] ram_raddr,
	input  logic [7:0]             ram_rdata,
	input  logic                   pop,
	output logic                   empty,
	output logic [2:0]             result_kind,
	output logic [7:0]             line_char,
	output logic                   run_last,
	output tla_pkg::back_stat_t    bstat
);

	tla_pkg::bk_state_t     state_q, state_d;
	logic [tla_pkg::AW-1:0] idx_q, idx_d;
	logic [tla_pkg::CW-1:0] n_q, n_d;
	logic                   out_v_q, out_v_d;
	tla_pkg::kind_t         out_kind_q, out_kind_d;
	logic [7:0]             out_char_q, out_char_d;
	logic                   out_last_q, out_last_d;
	logic                   load;
	logic                   taken;
	logic                   slot_free;
	logic                   last_char;
	logic                   done;

	assign taken     = pop && out_v_q;
	assign slot_free = !out_v_q || pop;
	assign last_char = (tla_pkg::CW'(idx_q) + tla_pkg::CW'(1)) == n_q;

	// command sequencer: single results or a store read sweep
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		n_d        = n_q;
		cmd_pop    = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = idx_q;
		load       = 1'b0;
		out_kind_d = out_kind_q;
		out_char_d = out_char_q;
		out_last_d = out_last_q;
		done       = 1'b0;
		case (state_q)
			tla_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					if (cmd.drain) begin
						cmd_pop   = 1'b1;
						ram_re    = 1'b1;
						ram_raddr = '0;
						idx_d     = '0;
						n_d       = cmd.count;
						state_d   = tla_pkg::BK_CAP;
					end else if (slot_free) begin
						cmd_pop    = 1'b1;
						load       = 1'b1;
						out_kind_d = cmd.kind;
						out_char_d = '0;
						out_last_d = 1'b1;
					end
				end
			end
			tla_pkg::BK_CAP: begin
				// read data for idx_q is ready; move it out and fetch the next
				if (slot_free) begin
					load       = 1'b1;
					out_kind_d = tla_pkg::KIND_CHAR;
					out_char_d = ram_rdata;
					out_last_d = last_char;
					if (last_char) begin
						done    = 1'b1;
						state_d = tla_pkg::BK_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + tla_pkg::AW'(1);
						idx_d     = idx_q + tla_pkg::AW'(1);
					end
				end
			end
			default: begin
				state_d = tla_pkg::BK_IDLE;
			end
		endcase
		if (load) begin
			out_v_d = 1'b1;
		end else if (taken) begin
			out_v_d = 1'b0;
		end else begin
			out_v_d = out_v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tla_pkg::BK_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_v_q <= out_v_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		n_q        <= n_d;
		out_kind_q <= out_kind_d;
		out_char_q <= out_char_d;
		out_last_q <= out_last_d;
	end

	assign empty            = !out_v_q;
	assign result_kind      = out_kind_q;
	assign line_char        = out_char_q;
	assign run_last         = out_last_q;
	assign bstat.draining   = state_q == tla_pkg::BK_CAP;
	assign bstat.drain_done = done;

endmodule

/* test/text_line_assembler_core_tb.sv */
`timescale 1ns / 100ps

module text_line_assembler_core_tb;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE       = 8;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int PHASE_WORDS  = 35;

	typedef struct {
		tla_pkg::kind_t kind;
		logic [7:0]     ch;
		logic           last;
	} line_result_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_char;
	logic       chunk_end;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [6:0] cfg_data;
	logic       empty;
	logic       pop;
	logic [2:0] result_kind;
	logic [7:0] line_char;
	logic       run_last;

	// shadow of the assembler state
	logic [7:0]                  shadow_line [tla_pkg::LINE_DEPTH];
	int                          shadow_fill;
	bit                          shadow_skip;
	logic [tla_pkg::LIMIT_W-1:0] shadow_limit;

	line_result_t line_results_due [$];

	int  errors;
	int  words_sent;
	int  results_seen;
	int  lines_drained;
	int  overflows;
	int  discards;
	int  cycle_count;
	int  hold_off_left;
	bit  calm;

	text_line_assembler_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_char     (in_char),
		.chunk_end   (chunk_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.empty       (empty),
		.pop         (pop),
		.result_kind (result_kind),
		.line_char   (line_char),
		.run_last    (run_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				line_results_due.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// a byte that is neither printable nor newline, CR often
	function automatic logic [7:0] pick_junk();
		logic [7:0] c;
		c = ($urandom_range(0, 3) == 0) ? 8'h0D : 8'($urandom_range(0, 255));
		while (c == tla_pkg::NL_CHAR ||
			(c >= tla_pkg::PRINT_LO && c <= tla_pkg::PRINT_HI))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic void add_result(tla_pkg::kind_t kind, logic [7:0] ch, logic last);
		line_result_t r;
		r.kind = kind;
		r.ch   = ch;
		r.last = last;
		line_results_due.push_back(r);
	endfunction

	// expected results of one accepted word
	function automatic void assemble_char(logic [7:0] ch, logic ce);
		int  eff;
		bit  below;
		eff   = (shadow_limit < tla_pkg::LINE_DEPTH) ? int'(shadow_limit) :
			tla_pkg::LINE_DEPTH;
		below = shadow_fill < eff;
		if (shadow_skip) begin
			if (ce)
				shadow_skip = 1'b0;
			add_result(tla_pkg::KIND_DISCARD, 8'h00, 1'b1);
			return;
		end
		if (ch == tla_pkg::NL_CHAR) begin
			if (below) begin
				if (shadow_fill == 0)
					add_result(tla_pkg::KIND_EMPTY, 8'h00, 1'b1);
				for (int k = 0; k < shadow_fill; k++)
					add_result(tla_pkg::KIND_CHAR, shadow_line[tla_pkg::AW'(k)],
						k == shadow_fill - 1);
				shadow_fill = 0;
				return;
			end
			shadow_fill = 0;
			if (!ce)
				shadow_skip = 1'b1;
			add_result(tla_pkg::KIND_OVERFLOW, 8'h00, 1'b1);
			return;
		end
		if (below) begin
			if (ch >= tla_pkg::PRINT_LO && ch <= tla_pkg::PRINT_HI) begin
				shadow_line[tla_pkg::AW'(shadow_fill)] = ch;
				shadow_fill++;
			end
			add_result(tla_pkg::KIND_ACCEPT, 8'h00, 1'b1);
			return;
		end
		if (!ce)
			shadow_skip = 1'b1;
		add_result(tla_pkg::KIND_OVERFLOW, 8'h00, 1'b1);
	endfunction

	// offer one word, hold push high afterwards for a back-to-back word
	task automatic send_char(input logic [7:0] ch, input logic ce);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push      <= 1'b1;
		in_char   <= ch;
		chunk_end <= ce;
		@(posedge clk);
		while (full) @(posedge clk);
		assemble_char(ch, ce);
		words_sent++;
	endtask

	// printable text with some junk, closed by a newline
	task automatic send_line(input int len);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				c = pick_junk();
			else
				c = 8'($urandom_range(tla_pkg::PRINT_LO, tla_pkg::PRINT_HI));
			send_char(c, $urandom_range(0, 5) == 0);
		end
		send_char(tla_pkg::NL_CHAR, $urandom_range(0, 2) == 0);
	endtask

	// stop sending and let every due result come out
	task automatic drain_all();
		@(negedge clk);
		push <= 1'b0;
		while (line_results_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_limit(input logic [6:0] value);
		drain_all();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: random pop gaps, plus a long hold-off on request
	initial begin : receiver
		int gap;
		gap = 0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				pop <= 1'b0;
				hold_off_left--;
			end else if (gap > 0) begin
				pop <= 1'b0;
				gap--;
			end else begin
				pop <= 1'b1;
				gap = pick_gap();
			end
		end
	end

	// compare each popped word with the oldest due result
	always @(posedge clk) begin : check_results
		line_result_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (line_results_due.size() == 0) begin
				$error("unexpected result: result_kind %0d line_char %02h run_last %0b",
					result_kind, line_char, run_last);
				errors++;
			end else begin
				want = line_results_due.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
					errors++;
				end
				if (line_char !== want.ch) begin
					$error("line_char: expected %02h, actual %02h", want.ch, line_char);
					errors++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %0b, actual %0b", want.last, run_last);
					errors++;
				end
				if (want.kind == tla_pkg::KIND_CHAR && want.last)
					lines_drained++;
				if (want.kind == tla_pkg::KIND_OVERFLOW)
					overflows++;
				if (want.kind == tla_pkg::KIND_DISCARD)
					discards++;
			end
		end
	end

	// printable edges, dropped bytes, empty line, short line
	task automatic test_char_classes();
		send_char(tla_pkg::NL_CHAR, 1'b1);
		send_char(tla_pkg::PRINT_LO, 1'b0);
		send_char(tla_pkg::PRINT_HI, 1'b0);
		send_char(8'h1F, 1'b0);
		send_char(8'h7F, 1'b0);
		send_char(8'h0D, 1'b1);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(tla_pkg::NL_CHAR, 1'b0);
		send_char("A", 1'b1);
		send_char(tla_pkg::NL_CHAR, 1'b1);
	endtask

	// overflow with and without chunk end, discarding to the chunk end
	task automatic test_overflow_and_discard();
		write_limit(7'd2);
		send_char("a", 1'b0);
		send_char("b", 1'b0);
		send_char("c", 1'b0);
		send_char("d", 1'b0);
		send_char("e", 1'b1);
		send_char(tla_pkg::NL_CHAR, 1'b1);
		send_char("q", 1'b0);
		send_char("r", 1'b0);
		send_char("z", 1'b1);
		send_char(tla_pkg::NL_CHAR, 1'b0);
		send_char("w", 1'b1);
		send_char(tla_pkg::NL_CHAR, 1'b1);
	endtask

	// longest line while the receiver holds off, then a full pause
	task automatic test_backpressure();
		write_limit(7'd64);
		calm = 1'b1;
		hold_off_left = 400;
		for (int i = 0; i < tla_pkg::LINE_DEPTH - 1; i++)
			send_char(8'($urandom_range(tla_pkg::PRINT_LO, tla_pkg::PRINT_HI)), 1'b0);
		send_char(tla_pkg::NL_CHAR, 1'b0);
		for (int i = 0; i < 8; i++)
			send_char(8'($urandom_range(tla_pkg::PRINT_LO, tla_pkg::PRINT_HI)), 1'b0);
		send_char(tla_pkg::NL_CHAR, 1'b1);
		calm = 1'b0;
		drain_all();
	endtask

	// random traffic across limit settings, extremes included
	task automatic test_random_limits();
		logic [6:0] limits [7];
		int         eff;
		int         start;
		int         len;
		limits = '{7'd0, 7'd127, 7'd1, 7'($urandom_range(3, 63)),
			7'($urandom_range(65, 126)), 7'd2, 7'd64};
		foreach (limits[p]) begin
			write_limit(limits[p]);
			calm = (p == 3);
			eff = (limits[p] < tla_pkg::LINE_DEPTH) ? int'(limits[p]) :
				tla_pkg::LINE_DEPTH;
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				if ($urandom_range(0, 6) == 0) begin
					send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else begin
					if ($urandom_range(0, 3) == 0)
						len = $urandom_range(0, eff + 2);
					else
						len = $urandom_range(0, (eff + 1 < 8) ? eff + 1 : 8);
					send_line(len);
				end
				if ($urandom_range(0, 40) == 0)
					drain_all();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		in_char       = 8'h00;
		chunk_end     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 7'd0;
		errors        = 0;
		words_sent    = 0;
		results_seen  = 0;
		lines_drained = 0;
		overflows     = 0;
		discards      = 0;
		hold_off_left = 0;
		calm          = 1'b0;
		shadow_fill   = 0;
		shadow_skip   = 1'b0;
		shadow_limit  = tla_pkg::LIMIT_RESET;
		foreach (shadow_line[i])
			shadow_line[i] = 8'h00;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_char_classes();
		test_overflow_and_discard();
		test_backpressure();
		test_random_limits();
		drain_all();

		$display("sent %0d words, checked %0d results", words_sent, results_seen);
		$display("%0d lines drained, %0d overflows, %0d discarded words",
			lines_drained, overflows, discards);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
